// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the bond-table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever cond holds at a clock edge, result must hold at the same edge.
`define VBO_ASSERT_IMPLY(label, clk, rst, cond, result) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (result)) \
      else $error("Same-cycle implication failed.");

// Whenever cond holds at a clock edge, result must hold at the next edge.
`define VBO_ASSERT_NEXT(label, clk, rst, cond, result) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (result)) \
      else $error("Next-cycle implication failed.");

// The condition must never hold.
`define VBO_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("Forbidden condition observed.");

`endif

// ===== hw/rtl/vbo_pkg.sv =====
// ----------------------------------------------------------------------------
// vbo_pkg
// Types and constants of the valence-bond table block.
// ----------------------------------------------------------------------------
package vbo_pkg;

   localparam int PAIRS   = 8;
   localparam int ROW_W   = $clog2(PAIRS);
   localparam int SITE_W  = 4;
   localparam int OP_W    = 2;
   localparam int IDX_W   = 3;
   localparam int COUNT_W = 16;

   typedef logic [SITE_W-1:0]  site_type;
   typedef logic [ROW_W-1:0]   row_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [OP_W-1:0]    opfield_type;

   localparam count_type COUNT_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_APPLY = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

// ===== hw/rtl/vbo_if.sv =====
// ----------------------------------------------------------------------------
// vbo_req_if / vbo_rsp_if
// Valid/ready channels for requests and responses of the bond-table block.
// ----------------------------------------------------------------------------
interface vbo_req_if import vbo_pkg::*; ();
   logic        valid;
   logic        ready;
   opfield_type operation;
   site_type    site_a;
   site_type    site_b;
   idx_type     pair_index;

   modport source (output valid, operation, site_a, site_b, pair_index, input ready);
   modport sink   (input valid, operation, site_a, site_b, pair_index, output ready);
endinterface

interface vbo_rsp_if import vbo_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      changed;
   count_type weight_count;
   logic      site_missing;

   modport source (output valid, changed, weight_count, site_missing, input ready);
   modport sink   (input valid, changed, weight_count, site_missing, output ready);
endinterface

// ===== hw/rtl/vbo_ctrl.sv =====
// ----------------------------------------------------------------------------
// vbo_ctrl
// Controller: takes one request, runs it through the datapath, holds the
// response until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vbo_ctrl import vbo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      valid_in = valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
               ready_in = 1'b0;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            valid_in = 1'b1;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
               valid_in = 1'b0;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
            ready_in = 1'b1;
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready   = ready_ff;
   assign rsp_valid   = valid_ff;
   assign cmd.capture = req_valid && ready_ff;
   assign cmd.execute = (state_ff == S_EXEC);

   `VBO_ASSERT_NEVER(a_ready_and_valid, clock, reset, ready_ff && valid_ff)
   `VBO_ASSERT_NEXT(a_capture_then_exec, clock, reset, cmd.capture, cmd.execute)
   `VBO_ASSERT_NEXT(a_exec_then_resp, clock, reset, cmd.execute, valid_ff && !ready_ff)

endmodule

// ===== hw/rtl/vbo_dpath.sv =====
// ----------------------------------------------------------------------------
// vbo_dpath
// Datapath: request register, bond table, parallel site match, bond
// rearrangement and saturating weight counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vbo_dpath import vbo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  opfield_type operation,
   input  site_type    site_a,
   input  site_type    site_b,
   input  idx_type     pair_index,
   output logic        changed,
   output count_type   weight_count,
   output logic        site_missing
);

   opfield_type op_ff;
   site_type    sa_ff;
   site_type    sb_ff;
   idx_type     idx_ff;

   site_type    pair_tbl_ff [PAIRS][2];
   site_type    pair_tbl_in [PAIRS][2];
   count_type   count_ff, count_in;
   logic        changed_ff, changed_in;
   logic        missing_ff, missing_in;

   logic        found_a, found_b;
   row_type     row_a, row_b;
   logic        slot_a, slot_b;
   site_type    partner_a;
   logic        idx_ok;
   row_type     load_row;
   logic        clear_exec;

   // All slots are compared at once; a later match overrides an earlier one,
   // so the highest matching row wins, and within that row the second slot.
   always_comb begin
      found_a   = 1'b0;
      found_b   = 1'b0;
      row_a     = '0;
      row_b     = '0;
      slot_a    = 1'b0;
      slot_b    = 1'b0;
      partner_a = '0;
      for (int r = 0; r < PAIRS; r++) begin
         for (int s = 0; s < 2; s++) begin
            if (pair_tbl_ff[r][s] == sa_ff) begin
               found_a   = 1'b1;
               row_a     = ROW_W'(r);
               slot_a    = 1'(s);
               partner_a = pair_tbl_ff[r][1-s];
            end
            if (pair_tbl_ff[r][s] == sb_ff) begin
               found_b = 1'b1;
               row_b   = ROW_W'(r);
               slot_b  = 1'(s);
            end
         end
      end
   end

   assign idx_ok     = (32'(idx_ff) < PAIRS);
   assign load_row   = ROW_W'(idx_ff);
   assign clear_exec = cmd.execute && (op_ff == OP_CLEAR);

   always_comb begin
      pair_tbl_in = pair_tbl_ff;
      count_in    = count_ff;
      changed_in  = 1'b0;
      missing_in  = 1'b0;
      if (cmd.execute) begin
         priority if (op_ff == OP_LOAD) begin
            if (idx_ok) begin
               pair_tbl_in[load_row][0] = sa_ff;
               pair_tbl_in[load_row][1] = sb_ff;
            end
         end else if (op_ff == OP_APPLY) begin
            if (!found_a || !found_b) begin
               missing_in = 1'b1;
            end else if (row_a != row_b) begin
               // The partner of site_a moves next to site_b's old partner,
               // and site_b takes its place beside site_a.
               pair_tbl_in[row_b][slot_b]  = partner_a;
               pair_tbl_in[row_a][!slot_a] = sb_ff;
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               changed_in = 1'b1;
            end
         end else if (op_ff == OP_CLEAR) begin
            count_in = '0;
         end else begin
            count_in = count_ff;
         end
      end else begin
         changed_in = changed_ff;
         missing_in = missing_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= operation;
         sa_ff  <= site_a;
         sb_ff  <= site_b;
         idx_ff <= pair_index;
      end
      pair_tbl_ff <= pair_tbl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         changed_ff <= 1'b0;
         missing_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         changed_ff <= changed_in;
         missing_ff <= missing_in;
      end
   end

   assign changed      = changed_ff;
   assign weight_count = count_ff;
   assign site_missing = missing_ff;

   `VBO_ASSERT_NEVER(a_changed_and_missing, clock, reset, changed_ff && missing_ff)
   `VBO_ASSERT_NEXT(a_count_monotonic, clock, reset, !clear_exec, count_ff >= $past(count_ff))
   `VBO_ASSERT_NEXT(a_clear_zeroes, clock, reset, clear_exec, count_ff == '0)

endmodule

// ===== hw/rtl/valence_bond_operator_apply.sv =====
// ----------------------------------------------------------------------------
// valence_bond_operator_apply
// Valence-bond table: loads bond pairs, applies bond operators that
// rearrange pairs, and counts rearrangements in a saturating counter.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake     Payload
// req       in         valid/ready   operation, site_a, site_b, pair_index
// rsp       out        valid/ready   changed, weight_count, site_missing
//
// Each transaction passes capture, execute and the response register in turn.
// The execute cycle matches all 16 table slots in parallel and rewrites two.
// A new request is accepted in the cycle after the response is taken.
// Synchronous reset clears the controller, the weight counter and the
// response flags; the pair table holds no defined value until loaded.
// ----------------------------------------------------------------------------
module valence_bond_operator_apply import vbo_pkg::*; (
   input logic      clock,
   input logic      reset,
   vbo_req_if.sink  req,
   vbo_rsp_if.source rsp
);

   cmd_type cmd;

   vbo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   vbo_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .operation    (req.operation),
      .site_a       (req.site_a),
      .site_b       (req.site_b),
      .pair_index   (req.pair_index),
      .changed      (rsp.changed),
      .weight_count (rsp.weight_count),
      .site_missing (rsp.site_missing)
   );

endmodule

// ===== tb/sv/valence_bond_operator_apply_tb.sv =====
// ----------------------------------------------------------------------------
// valence_bond_operator_apply_tb
// Self-checking bench for the valence-bond table. A short table of directed
// requests covers reset, loads, the bond-operator corner cases and the
// unused operation. Random requests follow, mostly on shuffled full tables.
// Every response is compared field by field with the expected value of its
// directed row or with a behavioral copy of the bond table kept here.
// ----------------------------------------------------------------------------
module valence_bond_operator_apply_tb import vbo_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam opfield_type OP_NONE     = 2'd3;
   localparam int          RANDOM_REQS = 650;
   localparam int          MAX_PAUSE   = 14;
   localparam int          PRINT_CAP   = 100;
   localparam int          DRAIN_CYCLES = 10;

   typedef struct packed {
      opfield_type op;
      site_type    a;
      site_type    b;
      idx_type     idx;
   } bond_request;

   typedef struct packed {
      logic      changed;
      count_type weight;
      logic      missing;
   } bond_result;

   typedef struct packed {
      bond_request rq;
      logic        typed;
      bond_result  want;
   } directed_row;

   localparam bond_result NO_EFFECT = '{1'b0, 16'd0, 1'b0};

   // Rows marked typed carry their expected response; the others are
   // checked against the bond-table model.
   localparam directed_row DIRECTED_ROWS [0:21] = '{
      '{'{OP_CLEAR, 4'd0,  4'd0,  3'd0}, 1'b1, NO_EFFECT},
      '{'{OP_NONE,  4'd0,  4'd0,  3'd0}, 1'b1, NO_EFFECT},
      '{'{OP_LOAD,  4'd14, 4'd15, 3'd7}, 1'b1, NO_EFFECT},
      '{'{OP_LOAD,  4'd0,  4'd1,  3'd0}, 1'b1, NO_EFFECT},
      '{'{OP_LOAD,  4'd2,  4'd3,  3'd1}, 1'b1, NO_EFFECT},
      '{'{OP_LOAD,  4'd4,  4'd5,  3'd2}, 1'b1, NO_EFFECT},
      '{'{OP_LOAD,  4'd6,  4'd7,  3'd3}, 1'b1, NO_EFFECT},
      '{'{OP_LOAD,  4'd8,  4'd9,  3'd4}, 1'b1, NO_EFFECT},
      '{'{OP_LOAD,  4'd10, 4'd11, 3'd5}, 1'b1, NO_EFFECT},
      '{'{OP_LOAD,  4'd12, 4'd13, 3'd6}, 1'b1, NO_EFFECT},
      '{'{OP_APPLY, 4'd0,  4'd0,  3'd0}, 1'b1, NO_EFFECT},
      '{'{OP_APPLY, 4'd0,  4'd1,  3'd0}, 1'b1, NO_EFFECT},
      '{'{OP_APPLY, 4'd0,  4'd15, 3'd0}, 1'b1, '{1'b1, 16'd1, 1'b0}},
      '{'{OP_LOAD,  4'd15, 4'd15, 3'd3}, 1'b1, '{1'b0, 16'd1, 1'b0}},
      '{'{OP_APPLY, 4'd6,  4'd2,  3'd0}, 1'b1, '{1'b0, 16'd1, 1'b1}},
      '{'{OP_APPLY, 4'd15, 4'd4,  3'd0}, 1'b0, NO_EFFECT},
      '{'{OP_APPLY, 4'd7,  4'd7,  3'd0}, 1'b0, NO_EFFECT},
      '{'{OP_CLEAR, 4'd0,  4'd0,  3'd0}, 1'b1, NO_EFFECT},
      '{'{OP_APPLY, 4'd5,  4'd14, 3'd0}, 1'b0, NO_EFFECT},
      '{'{OP_NONE,  4'd15, 4'd15, 3'd7}, 1'b0, NO_EFFECT},
      '{'{OP_APPLY, 4'd15, 4'd15, 3'd7}, 1'b0, NO_EFFECT},
      '{'{OP_APPLY, 4'd4,  4'd9,  3'd0}, 1'b0, NO_EFFECT}
   };

   logic clock = 1'b0;
   logic reset;

   vbo_req_if req_bus ();
   vbo_rsp_if rsp_bus ();

   valence_bond_operator_apply dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Model state of the block.
   site_type   bond_table [PAIRS][2];
   count_type  weight_model;
   bond_result pending_results [$];
   int         mismatches = 0;
   bit         no_gaps = 1'b0;

   function automatic int draw_pause();
      return no_gaps ? 0 : $urandom_range(0, MAX_PAUSE);
   endfunction

   // Last slot holding the site wins, scanning rows upward.
   function automatic bit find_site(input site_type s, output int row, output int slot);
      bit hit;
      hit  = 1'b0;
      row  = 0;
      slot = 0;
      for (int r = 0; r < PAIRS; r++) begin
         for (int k = 0; k < 2; k++) begin
            if (bond_table[r][k] == s) begin
               row  = r;
               slot = k;
               hit  = 1'b1;
            end
         end
      end
      return hit;
   endfunction

   function automatic bond_result predict_bond_step(input bond_request rq);
      bond_result res;
      int ra, pa, rb, pb;
      bit fa, fb;
      res = '0;
      case (rq.op)
         OP_LOAD: begin
            bond_table[rq.idx][0] = rq.a;
            bond_table[rq.idx][1] = rq.b;
         end
         OP_APPLY: begin
            fa = find_site(rq.a, ra, pa);
            fb = find_site(rq.b, rb, pb);
            if (!fa || !fb) begin
               res.missing = 1'b1;
            end else if (ra != rb) begin
               // The partner of site_a moves to where site_b was.
               bond_table[rb][pb]     = bond_table[ra][1 - pa];
               bond_table[ra][1 - pa] = rq.b;
               if (weight_model != COUNT_MAX) weight_model++;
               res.changed = 1'b1;
            end
         end
         OP_CLEAR: begin
            weight_model = '0;
         end
         default: ;
      endcase
      res.weight = weight_model;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
   endtask

   // Called at a rising edge; returns at the edge where the transaction is taken.
   task automatic send_request(input bond_request rq, input bit typed, input bond_result want);
      int pause;
      bond_result predicted;
      pause = draw_pause();
      if (pause > 0) begin
         req_bus.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= rq.op;
      req_bus.site_a     <= rq.a;
      req_bus.site_b     <= rq.b;
      req_bus.pair_index <= rq.idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = predict_bond_step(rq);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // Loads all rows with a random permutation of the sixteen sites.
   task automatic load_shuffled_pairs();
      site_type deck [16];
      site_type t;
      int j;
      bond_request rq;
      for (int i = 0; i < 16; i++) deck[i] = site_type'(i);
      for (int i = 15; i > 0; i--) begin
         j       = $urandom_range(0, i);
         t       = deck[i];
         deck[i] = deck[j];
         deck[j] = t;
      end
      for (int r = 0; r < PAIRS; r++) begin
         rq = '{OP_LOAD, deck[2 * r], deck[2 * r + 1], idx_type'(r)};
         send_request(rq, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      bond_result want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response, weight_count", rsp_bus.weight_count, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.changed !== want.changed)
               report_mismatch("changed", rsp_bus.changed, want.changed);
            if (rsp_bus.weight_count !== want.weight)
               report_mismatch("weight_count", rsp_bus.weight_count, want.weight);
            if (rsp_bus.site_missing !== want.missing)
               report_mismatch("site_missing", rsp_bus.site_missing, want.missing);
         end
      end
   end

   // Response side: a fresh stall is drawn for every transaction.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_pause();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   initial begin
      bond_request rq;
      int random_reqs;
      int pick;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_NONE;
      req_bus.site_a     <= '0;
      req_bus.site_b     <= '0;
      req_bus.pair_index <= '0;
      for (int r = 0; r < PAIRS; r++) begin
         bond_table[r][0] = '0;
         bond_table[r][1] = '0;
      end
      weight_model = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_request(DIRECTED_ROWS[i].rq, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

      // Mostly applies on shuffled tables; stray loads break the table up
      // so that duplicate and missing sites show up between reshuffles.
      random_reqs = 0;
      while (random_reqs < RANDOM_REQS) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            load_shuffled_pairs();
            random_reqs += PAIRS;
         end else begin
            rq.a   = site_type'($urandom_range(0, 15));
            rq.b   = site_type'($urandom_range(0, 15));
            rq.idx = idx_type'($urandom_range(0, 7));
            if (pick < 70)      rq.op = OP_APPLY;
            else if (pick < 85) rq.op = OP_LOAD;
            else if (pick < 93) rq.op = OP_CLEAR;
            else                rq.op = OP_NONE;
            send_request(rq, 1'b0, '0);
            random_reqs++;
         end
         if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
      end

      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("valence_bond_operator_apply_tb: clean");
      end else begin
         $display("valence_bond_operator_apply_tb: errors");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("valence_bond_operator_apply_tb: errors");
      $finish;
   end

endmodule

// ===== valence_bond_operator_apply.f =====
+incdir+hw/rtl
hw/rtl/vbo_pkg.sv
hw/rtl/vbo_if.sv
hw/rtl/vbo_ctrl.sv
hw/rtl/vbo_dpath.sv
hw/rtl/valence_bond_operator_apply.sv
tb/sv/valence_bond_operator_apply_tb.sv
